### sv/bsa_pkg.sv
// Shared types and constants for the banker safety allocator.
// Holds the word layouts, status and action codes, and the controller command set.
// No dependencies; compile first.
`default_nettype none

package bsa_pkg;

	// Default sizing
	localparam int BSA_SLOTS       = 8;
	localparam int BSA_AMOUNT_BITS = 16;

	// Fixed field widths of the channel words
	localparam int SLOT_ID_BITS = 3;
	localparam int FIELD_BITS   = 16;
	localparam int STATUS_BITS  = 2;

	// Configuration port
	localparam int                   CFG_ADDR_BITS   = 2;
	localparam int                   CFG_DATA_BITS   = 32;
	localparam logic [CFG_ADDR_BITS-1:0] ADDR_INIT_AVAIL = 2'd0;

	// Action codes
	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Status codes
	localparam logic [STATUS_BITS-1:0] ST_GRANT  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_DENY   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_UNSAFE = 2'd2;

	typedef struct packed {
		logic                    action;
		logic [SLOT_ID_BITS-1:0] slot_id;
		logic [FIELD_BITS-1:0]   max_need;
		logic [FIELD_BITS-1:0]   request_amount;
	} item_word_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [FIELD_BITS-1:0]  available_now;
	} result_word_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture the incoming word
		logic lookup;      // read the item's slot from the tables
		logic check;       // decide release / deny / start the walk
		logic issue;       // read the next slot of the walk
		logic pass_start;  // restart the scan for another pass
		logic commit;      // keep or drop the trial grant
		logic emit;        // move the result into the output register
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_walk;
		logic last_issue;
		logic progress;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LOOKUP = 7'b0000010,
		S_CHECK  = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_DRAIN  = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_RESULT = 7'b1000000
	} ctl_state_t;

endpackage

`default_nettype wire

### sv/bsa_ctrl.sv
// Controller state machine of the banker safety allocator.
// Sequences lookup, decision, safety walk passes, commit and result hand-off.
// Depends on bsa_pkg.
`default_nettype none

module bsa_ctrl
	import bsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	// Take a new word only when idle
	assign item_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.need_walk ? S_WALK : S_RESULT;
			end
			S_WALK: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// another pass only if this one finished some slot
				if (stat.progress) begin
					cmd.pass_start = 1'b1;
					state_d        = S_WALK;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### sv/bsa_dp.sv
// Datapath of the banker safety allocator: pool, slot tables, walk unit, output register.
// Holdings and declared maxima sit in single-read-port tables; one slot is checked per cycle within a walk pass.
// Depends on bsa_pkg.
`default_nettype none

module bsa_dp
	import bsa_pkg::*;
#(
	parameter int SLOTS       = BSA_SLOTS,
	parameter int AMOUNT_BITS = BSA_AMOUNT_BITS
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_stat_t               stat,
	input  item_word_t             item,
	input  logic                   cfg_load,
	input  logic [AMOUNT_BITS-1:0] cfg_value,
	output result_word_t           result,
	output logic                   result_valid,
	input  logic                   result_stall
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WORK_W = AMOUNT_BITS + SLOT_W + 1;

	// Tables
	logic [AMOUNT_BITS-1:0] held_mem [SLOTS];
	logic [AMOUNT_BITS-1:0] dmax_mem [SLOTS];
	logic [AMOUNT_BITS-1:0] held_rd_q;
	logic [AMOUNT_BITS-1:0] dmax_rd_q;
	logic [SLOT_W-1:0]      rd_addr;

	// Per-slot flags
	logic [SLOTS-1:0] held_v_q;
	logic [SLOTS-1:0] reg_q;
	logic [SLOTS-1:0] fin_q;

	// Item and working registers
	logic                    act_q;
	logic [SLOT_ID_BITS-1:0] slot_q;
	logic [AMOUNT_BITS-1:0]  mx_q;
	logic [AMOUNT_BITS-1:0]  amt_q;
	logic [AMOUNT_BITS-1:0]  pool_q;
	logic [AMOUNT_BITS-1:0]  trial_h_q;
	logic [WORK_W-1:0]       work_q;
	logic [SLOT_W-1:0]       scan_q;
	logic                    progress_q;
	logic [STATUS_BITS-1:0]  res_status_q;
	logic                    eval_v_s1;
	logic [SLOT_W-1:0]       eval_idx_s1;
	result_word_t            result_q;
	logic                    result_valid_q;

	// Decode
	logic [SLOT_W-1:0]      slot_idx;
	logic                   in_range;
	logic                   short;
	logic [AMOUNT_BITS-1:0] held_item;
	logic [AMOUNT_BITS:0]   rel_sum;
	logic [AMOUNT_BITS-1:0] rel_pool;
	logic [AMOUNT_BITS:0]   trial_sum;
	logic [AMOUNT_BITS-1:0] trial_h;
	logic [SLOTS-1:0]       req_oh;
	logic                   safe;

	// Walk evaluation
	logic                   ev_is_req;
	logic                   ev_member;
	logic [AMOUNT_BITS-1:0] ev_max;
	logic [AMOUNT_BITS-1:0] ev_held;
	logic                   fits;

	assign slot_idx  = SLOT_W'(slot_q);
	assign in_range  = (32'(slot_q) < 32'(SLOTS));
	assign short     = (amt_q > pool_q);
	assign held_item = (in_range && held_v_q[slot_idx]) ? held_rd_q : '0;

	// Saturating release and trial holding
	assign rel_sum   = {1'b0, pool_q} + {1'b0, held_item};
	assign rel_pool  = rel_sum[AMOUNT_BITS] ? '1 : rel_sum[AMOUNT_BITS-1:0];
	assign trial_sum = {1'b0, held_item} + {1'b0, amt_q};
	assign trial_h   = trial_sum[AMOUNT_BITS] ? '1 : trial_sum[AMOUNT_BITS-1:0];

	// Requester mask and final safety verdict
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			req_oh[i] = (SLOT_W'(i) == slot_idx);
		end
	end
	assign safe = ~|((reg_q | req_oh) & ~fin_q);

	// Check the slot whose table entry arrived this cycle
	assign ev_is_req = (eval_idx_s1 == slot_idx);
	assign ev_member = reg_q[eval_idx_s1] | ev_is_req;
	assign ev_max    = ev_is_req ? mx_q : dmax_rd_q;
	assign ev_held   = ev_is_req ? trial_h_q : (held_v_q[eval_idx_s1] ? held_rd_q : '0);
	assign fits      = eval_v_s1 && ev_member && !fin_q[eval_idx_s1] && (ev_held <= ev_max)
		&& (WORK_W'(ev_max - ev_held) <= work_q);

	assign stat.need_walk  = in_range && (act_q == ACT_REQUEST) && !short;
	assign stat.last_issue = (scan_q == SLOT_W'(SLOTS - 1));
	assign stat.progress   = progress_q | fits;
	assign stat.out_free   = !result_valid_q || !result_stall;

	assign rd_addr = cmd.issue ? scan_q : slot_idx;

	// Table writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.commit && safe) begin
			held_mem[slot_idx] <= trial_h_q;
			dmax_mem[slot_idx] <= mx_q;
		end
		held_rd_q <= held_mem[rd_addr];
		dmax_rd_q <= dmax_mem[rd_addr];
	end

	// Control state: pool, flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q         <= '0;
			held_v_q       <= '0;
			reg_q          <= '0;
			fin_q          <= '0;
			eval_v_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			eval_v_s1 <= cmd.issue;
			if (cfg_load) begin
				pool_q <= cfg_value;
			end
			// release and walk start
			if (cmd.check && in_range) begin
				if (act_q == ACT_RELEASE) begin
					pool_q             <= rel_pool;
					held_v_q[slot_idx] <= 1'b0;
					reg_q[slot_idx]    <= 1'b0;
				end else if (!short) begin
					fin_q <= '0;
				end
			end
			if (fits) begin
				fin_q[eval_idx_s1] <= 1'b1;
			end
			// keep the trial grant when safe
			if (cmd.commit && safe) begin
				pool_q             <= pool_q - amt_q;
				held_v_q[slot_idx] <= 1'b1;
				reg_q[slot_idx]    <= 1'b1;
			end
			// output register
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		eval_idx_s1 <= scan_q;
		if (cmd.load) begin
			act_q  <= item.action;
			slot_q <= item.slot_id;
			mx_q   <= AMOUNT_BITS'(item.max_need);
			amt_q  <= AMOUNT_BITS'(item.request_amount);
		end
		if (cmd.check) begin
			if (!in_range) begin
				res_status_q <= ST_DENY;
			end else if (act_q == ACT_RELEASE) begin
				res_status_q <= reg_q[slot_idx] ? ST_GRANT : ST_DENY;
			end else if (short) begin
				res_status_q <= ST_DENY;
			end else begin
				trial_h_q  <= trial_h;
				work_q     <= WORK_W'(pool_q - amt_q);
				scan_q     <= '0;
				progress_q <= 1'b0;
			end
		end
		if (cmd.issue) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.pass_start) begin
			scan_q     <= '0;
			progress_q <= 1'b0;
		end else if (fits) begin
			progress_q <= 1'b1;
		end
		if (fits) begin
			work_q <= work_q + WORK_W'(ev_held);
		end
		if (cmd.commit) begin
			res_status_q <= safe ? ST_GRANT : ST_UNSAFE;
		end
		if (cmd.emit) begin
			result_q.status        <= res_status_q;
			result_q.available_now <= FIELD_BITS'(pool_q);
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

### sv/banker_safety_allocator_top.sv
// Top level of the banker safety allocator: channels, APB register, controller and datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_dp.
`default_nettype none

// One item is handled at a time. A release, a denied request or an out-of-range slot goes
// from acceptance through lookup and check straight to the result word. A request that
// passes the pool check runs a safety walk through the holding and maximum tables, which
// have one read port, so one slot is checked per cycle within a pass; passes repeat while
// the previous one finished at least one slot, up to one pass more than the slots that take
// part in the walk (the registered slots and the requester), so at most SLOTS + 1 passes.
// A finished result waits in an output register, so the next word is taken while the
// previous result is still stalled. Writing initial_available also reloads the available
// pool; holdings and registrations are kept.
module banker_safety_allocator_top
	import bsa_pkg::*;
#(
	parameter int SLOTS       = BSA_SLOTS,
	parameter int AMOUNT_BITS = BSA_AMOUNT_BITS
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	// item channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  item_word_t               item,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output result_word_t             result,
	// register port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	ctl_cmd_t               cmd;
	dp_stat_t               stat;
	logic                   cfg_load;
	logic [AMOUNT_BITS-1:0] init_avail_q;

	// Register write and readback
	assign pready   = 1'b1;
	assign cfg_load = psel && penable && pwrite && (paddr == ADDR_INIT_AVAIL);
	assign prdata   = (paddr == ADDR_INIT_AVAIL) ? CFG_DATA_BITS'(init_avail_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_avail_q <= '0;
		end else if (cfg_load) begin
			init_avail_q <= AMOUNT_BITS'(pwdata);
		end
	end

	bsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	bsa_dp #(
		.SLOTS       (SLOTS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_load     (cfg_load),
		.cfg_value    (AMOUNT_BITS'(pwdata)),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// An accepted word keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item taken while previous one in progress");

	// A new result appears only from work in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result word without an item in progress");

	// Status code three is never produced
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == ST_GRANT || result.status == ST_DENY
			|| result.status == ST_UNSAFE))
		else $error("illegal status code");

endmodule

`default_nettype wire

### sim/banker_safety_allocator_top_test.sv
// Self-checking testbench for banker_safety_allocator_top: directed table, then random phases.
// Depends on bsa_pkg and the allocator RTL; predicts every result word in-house.
`default_nettype none

module banker_safety_allocator_top_test;
	import bsa_pkg::*;

	localparam int NSLOT       = BSA_SLOTS;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 250;
	localparam int SETTLE      = 100;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_LEN = 600;

	// One row of the directed table: a register write or an item word
	typedef struct packed {
		logic         is_cfg;
		logic [31:0]  cfg;
		item_word_t   word;
		logic         typed;
		result_word_t want;
	} stim_row_t;

	localparam int NROWS = 25;
	localparam stim_row_t DIRECTED [0:NROWS-1] = '{
		// empty pool after reset
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd0, 16'd0, 16'd0}, 1'b1, '{ST_GRANT, 16'd0}},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd1, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_DENY, 16'd0}},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd7, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_DENY, 16'd0}},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd0, 16'd0, 16'd0}, 1'b1, '{ST_GRANT, 16'd0}},
		// full pool, upper data bits must be dropped
		'{1'b1, 32'hA5A5_FFFF, '0, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd0, 16'hFFFF, 16'd40000}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd1, 16'hFFFF, 16'd30000}, 1'b0, '0},
		// holding above the declared maximum
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd2, 16'd5, 16'd10}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd3, 16'd30000, 16'd25535}, 1'b0, '0},
		// reload the pool while slot 0 still holds, then overflow its holding
		'{1'b1, 32'h0000_FFFF, '0, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd0, 16'd60000, 16'd30000}, 1'b0, '0},
		// release saturates the pool
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd0, 16'd0, 16'd0}, 1'b1, '{ST_GRANT, 16'hFFFF}},
		'{1'b1, 32'd0, '0, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd5, 16'd0, 16'd0}, 1'b1, '{ST_GRANT, 16'd0}},
		// small pool: walk restarts after each finish
		'{1'b1, 32'h5A5A_000C, '0, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd1, 16'd10, 16'd4}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd2, 16'd9, 16'd5}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd2, 16'd7, 16'd4}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd1, 16'd10, 16'd4}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd2, 16'h1234, 16'h4321}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd2, 16'd0, 16'd0}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd7, 16'hFFFF, 16'd0}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_REQUEST, 3'd6, 16'h8000, 16'h0001}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd1, 16'd0, 16'd0}, 1'b0, '0},
		'{1'b0, 32'd0, '{ACT_RELEASE, 3'd5, 16'd0, 16'd0}, 1'b0, '0}
	};

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	item_word_t               item         = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	result_word_t             result;
	logic                     psel         = 1'b0;
	logic                     penable      = 1'b0;
	logic                     pwrite       = 1'b0;
	logic [CFG_ADDR_BITS-1:0] paddr        = ADDR_INIT_AVAIL;
	logic [CFG_DATA_BITS-1:0] pwdata       = '0;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	banker_safety_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Allocator state as the testbench sees it
	logic [15:0] pool_units;
	logic [15:0] held_units [NSLOT];
	logic [15:0] max_units  [NSLOT];
	bit          in_table   [NSLOT];

	result_word_t pending_outcomes [$];
	int           fail_count = 0;
	int           burst_left = 0;

	// Work out the result of one word and advance the allocator state
	function automatic result_word_t allocate_outcome(input item_word_t w);
		result_word_t r;
		int unsigned  req;
		int unsigned  work;
		int unsigned  mx;
		int unsigned  h;
		int unsigned  nh;
		int           s;
		bit           done [NSLOT];
		bit           member;
		bit           safe;
		logic [15:0]  old_pool;
		logic [15:0]  old_held;
		req = 32'(w.slot_id);
		r.status = ST_DENY;
		if (w.action == ACT_RELEASE) begin
			nh = 32'(pool_units) + 32'(held_units[req]);
			pool_units = (nh > 32'hFFFF) ? 16'hFFFF : nh[15:0];
			held_units[req] = '0;
			r.status = in_table[req] ? ST_GRANT : ST_DENY;
			in_table[req] = 1'b0;
		end else if (w.request_amount > pool_units) begin
			r.status = ST_DENY;
		end else begin
			// grant on trial
			old_pool = pool_units;
			old_held = held_units[req];
			nh = 32'(old_held) + 32'(w.request_amount);
			pool_units = old_pool - w.request_amount;
			held_units[req] = (nh > 32'hFFFF) ? 16'hFFFF : nh[15:0];
			// safety walk: finish the lowest fitting slot, restart from slot 0
			foreach (done[i]) done[i] = 1'b0;
			work = 32'(pool_units);
			s = 0;
			while (s < NSLOT) begin
				member = in_table[s] || (s == req);
				mx = (s == req) ? 32'(w.max_need) : 32'(max_units[s]);
				h = 32'(held_units[s]);
				if (member && !done[s] && h <= mx && (mx - h) <= work) begin
					done[s] = 1'b1;
					work += h;
					s = 0;
				end else begin
					s++;
				end
			end
			safe = 1'b1;
			for (s = 0; s < NSLOT; s++)
				if ((in_table[s] || s == req) && !done[s]) safe = 1'b0;
			if (safe) begin
				in_table[req] = 1'b1;
				max_units[req] = w.max_need;
				r.status = ST_GRANT;
			end else begin
				pool_units = old_pool;
				held_units[req] = old_held;
				r.status = ST_UNSAFE;
			end
		end
		r.available_now = pool_units;
		return r;
	endfunction

	// Sender gap: bursts with no gap, mostly no gap or short gaps, a few long ones
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			burst_left = $urandom_range(5, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word, wait for it to be taken, then queue its expected result
	task automatic send_word(input item_word_t w, input bit typed, input result_word_t want);
		int           gap;
		result_word_t outcome;
		gap = next_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		outcome = allocate_outcome(w);
		pending_outcomes.insert(pending_outcomes.size(), typed ? want : outcome);
	endtask

	// Drop valid and wait until the block has answered everything
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write initial_available, reload the pool, and read the register back
	task automatic write_pool_reg(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_INIT_AVAIL;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pool_units = value[15:0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= $urandom();
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'd0, value[15:0]}) begin
			$display("%0t: register read expected %h actual %h", $time, {16'd0, value[15:0]},
				prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check each taken word, stall at random, hold off once for a long stretch
	initial begin : result_side
		int           pause_left;
		int           flow_left;
		int           hold_left;
		int           results_seen;
		int           r;
		bit           pressure_done;
		result_word_t want;
		pause_left = 0;
		flow_left = 0;
		hold_left = 0;
		results_seen = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				results_seen++;
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected result word status %0d available %0d", $time,
						result.status, result.available_now);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							result.status);
						fail_count++;
					end
					if (result.available_now !== want.available_now) begin
						$display("%0t: available_now expected %0d actual %0d", $time,
							want.available_now, result.available_now);
						fail_count++;
					end
				end
			end
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (pause_left > 0) begin
				pause_left--;
				result_stall <= 1'b1;
			end else if (flow_left > 0) begin
				flow_left--;
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					flow_left = $urandom_range(1, 30);
					result_stall <= 1'b0;
				end else if (r < 92) begin
					pause_left = $urandom_range(0, 2);
					result_stall <= 1'b1;
				end else begin
					pause_left = $urandom_range(10, 50);
					result_stall <= 1'b1;
				end
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_outcomes.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: reset, directed table, then random phases with one pool setting each
	initial begin : stimulus
		item_word_t   w;
		logic [31:0]  v;
		int unsigned  lim;
		int unsigned  need;
		int           r;
		pool_units = '0;
		foreach (held_units[i]) begin
			held_units[i] = '0;
			max_units[i] = '0;
			in_table[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NROWS; i++) begin
			if (DIRECTED[i].is_cfg) begin
				settle();
				write_pool_reg(DIRECTED[i].cfg);
			end else begin
				send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			r = $urandom_range(0, 99);
			v = $urandom();
			if (p == 3 || (p != 5 && r < 10)) v[15:0] = 16'hFFFF;
			else if (p == 5 || r < 20) v[15:0] = 16'd0;
			else if (p == 0 || r < 80) v[15:0] = 16'($urandom_range(1, 200));
			write_pool_reg(v);
			lim = (v[15:0] < 16'd64) ? 64 : 32'(v[15:0]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				w.action = 1'($urandom());
				w.slot_id = 3'($urandom());
				w.max_need = 16'($urandom());
				w.request_amount = 16'($urandom());
				if (r < 10) begin
					// noise: every field at full width
					w.max_need = 16'($urandom());
					w.request_amount = 16'($urandom());
				end else if (r < 30) begin
					w.action = ACT_RELEASE;
				end else begin
					// mostly a request that the slot could plausibly carry
					w.action = ACT_REQUEST;
					if (in_table[w.slot_id] && $urandom_range(0, 3) != 0)
						w.max_need = max_units[w.slot_id];
					else
						w.max_need = 16'($urandom_range(0, lim));
					need = (w.max_need > held_units[w.slot_id]) ?
						32'(w.max_need) - 32'(held_units[w.slot_id]) : 0;
					if ($urandom_range(0, 9) < 7)
						w.request_amount = 16'($urandom_range(0, need));
					else
						w.request_amount = 16'($urandom_range(0, lim));
				end
				send_word(w, 1'b0, '0);
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
sv/bsa_pkg.sv
sv/bsa_ctrl.sv
sv/bsa_dp.sv
sv/banker_safety_allocator_top.sv
sim/banker_safety_allocator_top_test.sv
